@@ rtl/core/als_pkg.sv @@
// Shared constants for the addressable LED serializer.
package als_pkg;

   // Store and counter sizing
   localparam int NUM_LEDS_DEFAULT = 8;
   localparam int LED_INDEX_W      = 3;
   localparam int LED_INDEX_DEPTH  = 1 << LED_INDEX_W;
   localparam int WORD_W           = 32;
   localparam int BIT_CNT_W        = 5;
   localparam int TICK_W           = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_LOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_LOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LATCH_LOW = 3'd4;

   // Register reset values, in clock ticks
   localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 16'd70;
   localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 16'd60;
   localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 16'd35;
   localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 16'd80;
   localparam logic [TICK_W-1:0] LATCH_LOW_RESET = 16'd6000;

   // Request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [BIT_CNT_W-1:0] BIT_FIRST = 5'd31;

endpackage

@@ rtl/core/addressable_led_serializer.sv @@
// Top level of the one-wire addressable LED serializer.
//
// Usage:
//   req channel: one word per handshake. req_type selects a tick word (one clock
//   of line timing) or a colour write (req_colour_word into LED req_led_index;
//   indexes at or beyond NUM_LEDS are dropped).
//   rsp channel: one word per accepted req word, in order: the line level for
//   that tick, the pressed flag and a frame-done strobe.
//   csr channel: write the five tick-count registers (index 0..4); always ready.
//   Write them only while the block is idle.
// Timing: each accepted word is processed in the cycle it is accepted and its
//   result lands in the output register, so rsp_valid rises in the next cycle.
//   One word is taken every cycle unless stalled; the single output register sets that rate.
// Stall: req_ready stays high while the output register is empty or is being
//   drained; when rsp_ready is low with a result waiting, req_ready drops and
//   the result holds until taken.
// Reset: synchronous, active high. Registers return to their defaults, the
//   colour store is cleared at once, and the next frame opens with the low
//   reset period.
module addressable_led_serializer #(
   parameter int NUM_LEDS = als_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [als_pkg::LED_INDEX_W-1:0]      req_led_index,
   input  logic [als_pkg::WORD_W-1:0]           req_colour_word,
   input  logic                                 req_button_level,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_line_level,
   output logic                                 rsp_button_pressed,
   output logic                                 rsp_frame_done,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [als_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [als_pkg::TICK_W-1:0]           csr_data
);

   // Only the first eight LEDs (or all, if fewer) are writable; the rest always read as zero.
   localparam int STORE_DEPTH = (NUM_LEDS < als_pkg::LED_INDEX_DEPTH) ?
                                NUM_LEDS : als_pkg::LED_INDEX_DEPTH;
   localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LED_CNT_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   typedef enum logic [1:0] {
      PH_OPEN  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CLOSE = 2'd2
   } phase_type;

   // timing registers
   logic [als_pkg::TICK_W-1:0] one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;
   logic [als_pkg::TICK_W-1:0] latch_low_ff;

   // frame state
   logic [als_pkg::WORD_W-1:0]    store_ff [STORE_DEPTH];
   phase_type                     phase_ff, phase_in;
   logic [LED_CNT_W-1:0]          led_ff, led_in;
   logic [als_pkg::BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [als_pkg::WORD_W-1:0]    shift_ff, shift_in;
   logic                          half_ff, half_in;
   logic [als_pkg::TICK_W-1:0]    dur_ff, dur_in;
   logic                          pressed_ff, pressed_in;
   logic                          line_hold_ff, line_hold_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_line_ff, rsp_line_in;
   logic rsp_pressed_ff, rsp_pressed_in;
   logic rsp_done_ff, rsp_done_in;

   logic                          accept, tick, store_wr;
   logic [als_pkg::WORD_W-1:0]    store_rd, word_cur;
   logic                          load_word, bit_val, line_now;
   logic [als_pkg::TICK_W-1:0]    seg_limit, dur_inc;
   logic                          seg_end;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_type == als_pkg::REQ_TICK);
   assign store_wr  = accept && (req_type == als_pkg::REQ_WRITE) &&
                      ({1'b0, req_led_index} < (als_pkg::LED_INDEX_W+1)'(STORE_DEPTH));

   // Read the entry for the LED being sent; LEDs past the store read zero.
   always_comb begin
      if ({1'b0, led_ff} < (LED_CNT_W+1)'(STORE_DEPTH)) begin
         store_rd = store_ff[led_ff[STORE_IDX_W-1:0]];
      end else begin
         store_rd = '0;
      end
   end

   // Latch the word on the first tick of its top bit.
   assign load_word = (phase_ff == PH_DATA) && !half_ff && (dur_ff == '0) &&
                      (bit_ff == als_pkg::BIT_FIRST);
   assign word_cur  = load_word ? store_rd : shift_ff;
   assign bit_val   = word_cur[bit_ff];

   // Pick the segment length and line level for this phase.
   always_comb begin
      case (phase_ff)
         PH_DATA: begin
            line_now = !half_ff;
            if (!half_ff) begin
               seg_limit = bit_val ? one_high_ff : zero_high_ff;
            end else begin
               seg_limit = bit_val ? one_low_ff : zero_low_ff;
            end
         end
         default: begin
            line_now  = 1'b0;
            seg_limit = latch_low_ff;
         end
      endcase
   end

   // A zero-length register acts as one tick: the limit test passes at once.
   assign dur_inc = dur_ff + 1'b1;
   assign seg_end = (dur_inc >= seg_limit) || (dur_inc == '0);

   always_comb begin
      phase_in     = phase_ff;
      led_in       = led_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      half_in      = half_ff;
      dur_in       = dur_ff;
      pressed_in   = pressed_ff;
      line_hold_in = line_hold_ff;
      rsp_done_in  = 1'b0;

      if (tick) begin
         line_hold_in = line_now;
         dur_in       = seg_end ? '0 : dur_inc;
         case (phase_ff)
            PH_DATA: begin
               shift_in = word_cur;
               if (seg_end) begin
                  if (!half_ff) begin
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     if (bit_ff == '0) begin
                        bit_in = als_pkg::BIT_FIRST;
                        if (led_ff == LED_CNT_W'(NUM_LEDS - 1)) begin
                           led_in   = '0;
                           phase_in = PH_CLOSE;
                        end else begin
                           led_in = led_ff + 1'b1;
                        end
                     end else begin
                        bit_in = bit_ff - 1'b1;
                     end
                  end
               end
            end
            PH_CLOSE: begin
               if (seg_end) begin
                  pressed_in  = !req_button_level;
                  rsp_done_in = 1'b1;
                  phase_in    = PH_OPEN;
               end
            end
            default: begin
               // opening reset period; an unused code behaves the same
               if (seg_end) begin
                  phase_in = PH_DATA;
                  led_in   = '0;
                  bit_in   = als_pkg::BIT_FIRST;
                  half_in  = 1'b0;
               end else begin
                  phase_in = PH_OPEN;
               end
            end
         endcase
      end

      // A write word repeats the last driven level.
      rsp_line_in    = tick ? line_now : line_hold_ff;
      rsp_pressed_in = pressed_in;
      rsp_valid_in   = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= als_pkg::ONE_HIGH_RESET;
         one_low_ff   <= als_pkg::ONE_LOW_RESET;
         zero_high_ff <= als_pkg::ZERO_HIGH_RESET;
         zero_low_ff  <= als_pkg::ZERO_LOW_RESET;
         latch_low_ff <= als_pkg::LATCH_LOW_RESET;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
         phase_ff     <= PH_OPEN;
         led_ff       <= '0;
         bit_ff       <= als_pkg::BIT_FIRST;
         shift_ff     <= '0;
         half_ff      <= 1'b0;
         dur_ff       <= '0;
         pressed_ff   <= 1'b0;
         line_hold_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               als_pkg::REG_ONE_HIGH:  one_high_ff  <= csr_data;
               als_pkg::REG_ONE_LOW:   one_low_ff   <= csr_data;
               als_pkg::REG_ZERO_HIGH: zero_high_ff <= csr_data;
               als_pkg::REG_ZERO_LOW:  zero_low_ff  <= csr_data;
               als_pkg::REG_LATCH_LOW: latch_low_ff <= csr_data;
               default: ;
            endcase
         end
         if (store_wr) begin
            store_ff[req_led_index[STORE_IDX_W-1:0]] <= req_colour_word;
         end
         phase_ff     <= phase_in;
         led_ff       <= led_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         half_ff      <= half_in;
         dur_ff       <= dur_in;
         pressed_ff   <= pressed_in;
         line_hold_ff <= line_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Load the result payload only with a new word; hold it while stalled.
      if (accept) begin
         rsp_line_ff    <= rsp_line_in;
         rsp_pressed_ff <= rsp_pressed_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_level     = rsp_line_ff;
   assign rsp_button_pressed = rsp_pressed_ff;
   assign rsp_frame_done     = rsp_done_ff;

   // A pending frame-done result means the frame has just wrapped to its opening period.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> phase_ff == PH_OPEN)
      else $error("frame done reported outside the opening period");

   // The line is only driven high while bits are being sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_line_ff |-> phase_ff == PH_DATA)
      else $error("line high outside the data phase");

   // Every phase change starts a fresh segment.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != $past(phase_ff) |-> dur_ff == '0)
      else $error("phase changed with a running segment count");

endmodule

@@ sim/addressable_led_serializer_tb.sv @@
// Self-checking testbench for the addressable LED serializer, with a cycle-level line predictor.
`timescale 1ns / 100ps

module addressable_led_serializer_tb;

   localparam int LEDS        = als_pkg::NUM_LEDS_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;

   // CSR indexes past the last register; the block must drop writes to them
   localparam logic [als_pkg::CSR_INDEX_W-1:0] REG_SPARE_5 = 3'd5;
   localparam logic [als_pkg::CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [als_pkg::CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef enum logic [1:0] {PH_OPEN, PH_DATA, PH_CLOSE} frame_phase_type;

   typedef struct packed {
      logic line;
      logic pressed;
      logic done;
   } line_word_type;

   // Predicts the line, pressed flag and frame strobe for every accepted word
   // and checks each returned word against the oldest prediction.
   class line_scoreboard;
      logic [als_pkg::WORD_W-1:0]      colour_mem [LEDS];
      frame_phase_type                 phase;
      logic [als_pkg::LED_INDEX_W-1:0] led_pos;
      logic [als_pkg::BIT_CNT_W-1:0]   bit_pos;
      logic [als_pkg::WORD_W-1:0]      shift_bits;
      logic                            low_half;
      logic [als_pkg::TICK_W-1:0]      elapsed;
      logic                            pressed;
      logic                            held_line;
      logic [als_pkg::TICK_W-1:0]      t_one_high, t_one_low, t_zero_high, t_zero_low;
      logic [als_pkg::TICK_W-1:0]      t_latch;
      line_word_type                   pending_levels [$];
      int                              errors;
      int                              checked;

      function new();
         foreach (colour_mem[i]) colour_mem[i] = '0;
         phase       = PH_OPEN;
         led_pos     = '0;
         bit_pos     = als_pkg::BIT_FIRST;
         shift_bits  = '0;
         low_half    = 1'b0;
         elapsed     = '0;
         pressed     = 1'b0;
         held_line   = 1'b0;
         t_one_high  = als_pkg::ONE_HIGH_RESET;
         t_one_low   = als_pkg::ONE_LOW_RESET;
         t_zero_high = als_pkg::ZERO_HIGH_RESET;
         t_zero_low  = als_pkg::ZERO_LOW_RESET;
         t_latch     = als_pkg::LATCH_LOW_RESET;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_reg(logic [als_pkg::CSR_INDEX_W-1:0] idx,
                            logic [als_pkg::TICK_W-1:0] val);
         case (idx)
            als_pkg::REG_ONE_HIGH:  t_one_high  = val;
            als_pkg::REG_ONE_LOW:   t_one_low   = val;
            als_pkg::REG_ZERO_HIGH: t_zero_high = val;
            als_pkg::REG_ZERO_LOW:  t_zero_low  = val;
            als_pkg::REG_LATCH_LOW: t_latch     = val;
            default: ;
         endcase
      endfunction

      // Count one tick of the running segment; a zero limit behaves as one.
      function logic segment_over(logic [als_pkg::TICK_W-1:0] limit);
         elapsed = elapsed + 1'b1;
         if (elapsed >= limit || elapsed == '0) begin
            elapsed = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function line_word_type predict_line(logic typ, logic [als_pkg::LED_INDEX_W-1:0] idx,
                                           logic [als_pkg::WORD_W-1:0] word, logic btn);
         line_word_type              r;
         logic                       bit_val;
         logic [als_pkg::TICK_W-1:0] limit;
         r = '0;
         if (typ == als_pkg::REQ_WRITE) begin
            // a color write takes no time: repeat the held level
            if (idx < LEDS) colour_mem[idx] = word;
            r.line    = held_line;
            r.pressed = pressed;
            return r;
         end
         case (phase)
            PH_DATA: begin
               // latch the LED's word on the first tick of its top bit
               if (!low_half && elapsed == '0 && bit_pos == als_pkg::BIT_FIRST)
                  shift_bits = colour_mem[led_pos];
               bit_val = shift_bits[bit_pos];
               if (!low_half) begin
                  r.line = 1'b1;
                  limit  = bit_val ? t_one_high : t_zero_high;
               end else begin
                  r.line = 1'b0;
                  limit  = bit_val ? t_one_low : t_zero_low;
               end
               if (segment_over(limit)) begin
                  if (!low_half) begin
                     low_half = 1'b1;
                  end else begin
                     low_half = 1'b0;
                     if (bit_pos == '0) begin
                        bit_pos = als_pkg::BIT_FIRST;
                        if (int'(led_pos) + 1 >= LEDS) begin
                           led_pos = '0;
                           phase   = PH_CLOSE;
                        end else begin
                           led_pos = led_pos + 1'b1;
                        end
                     end else begin
                        bit_pos = bit_pos - 1'b1;
                     end
                  end
               end
            end
            PH_CLOSE: begin
               if (segment_over(t_latch)) begin
                  pressed = !btn;
                  r.done  = 1'b1;
                  phase   = PH_OPEN;
               end
            end
            default: begin
               if (segment_over(t_latch)) begin
                  phase    = PH_DATA;
                  led_pos  = '0;
                  bit_pos  = als_pkg::BIT_FIRST;
                  low_half = 1'b0;
               end
            end
         endcase
         held_line = r.line;
         r.pressed = pressed;
         return r;
      endfunction

      function void note_word(logic typ, logic [als_pkg::LED_INDEX_W-1:0] idx,
                              logic [als_pkg::WORD_W-1:0] word, logic btn);
         pending_levels.push_back(predict_line(typ, idx, word, btn));
      endfunction

      task report(string what, logic got, logic want);
         $display("mismatch at result %0d: %s got %0b want %0b", checked, what, got, want);
         errors++;
      endtask

      task check_word(logic line, logic prs, logic done);
         line_word_type want;
         if (pending_levels.size() == 0) begin
            $display("mismatch at result %0d: word with no request outstanding", checked);
            errors++;
            return;
         end
         want = pending_levels.pop_front();
         if (line !== want.line)    report("line_level", line, want.line);
         if (prs !== want.pressed)  report("button_pressed", prs, want.pressed);
         if (done !== want.done)    report("frame_done", done, want.done);
         checked++;
      endtask
   endclass

   // Clock, reset and block ports; every input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_type = als_pkg::REQ_TICK;
   logic [als_pkg::LED_INDEX_W-1:0] req_led_index = '0;
   logic [als_pkg::WORD_W-1:0]      req_colour_word = '0;
   logic                            req_button_level = 1'b1;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_line_level, rsp_button_pressed, rsp_frame_done;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [als_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [als_pkg::TICK_W-1:0]      csr_data = '0;

   // Steady stretches: no sender gaps and no receiver stalls.
   logic steady = 1'b0;

   line_scoreboard sb = new();

   int cycles = 0;
   int stall_left = 0;

   addressable_led_serializer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_led_index      (req_led_index),
      .req_colour_word    (req_colour_word),
      .req_button_level   (req_button_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_level     (rsp_line_level),
      .rsp_button_pressed (rsp_button_pressed),
      .rsp_frame_done     (rsp_frame_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // Sample every handshake at the edge. Check returned words before noting the
   // new request so the oldest prediction is always matched first.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_line_level, rsp_button_pressed, rsp_frame_done);
         if (req_valid && req_ready)
            sb.note_word(req_type, req_led_index, req_colour_word, req_button_level);
         if (csr_valid && csr_ready)
            sb.set_reg(csr_index, csr_data);
      end
   end

   // Receiver: mostly ready, with short stalls and an occasional long one.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (steady || $urandom_range(0, 99) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end
   end

   // Random tick count in a range, sized for the timing registers.
   function automatic logic [als_pkg::TICK_W-1:0] rand_ticks(input int lo, input int hi);
      return (als_pkg::TICK_W)'($urandom_range(hi, lo));
   endfunction

   // Present one request word and hold it until the block takes it. Valid
   // stays high on return so back-to-back words need no extra assignment.
   task automatic send_word(input logic typ, input logic [als_pkg::LED_INDEX_W-1:0] idx,
                            input logic [als_pkg::WORD_W-1:0] word, input logic btn);
      req_valid        <= 1'b1;
      req_type         <= typ;
      req_led_index    <= idx;
      req_colour_word  <= word;
      req_button_level <= btn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid for a random gap: usually none, sometimes short, rarely long.
   task automatic idle_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      n    = 0;
      if (!steady) begin
         if (pick >= 95)      n = $urandom_range(10, 40);
         else if (pick >= 70) n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold one register write until the port takes it; the caller drops valid.
   task automatic write_reg(input logic [als_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [als_pkg::TICK_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Load all five timing registers, then release the port.
   task automatic load_timing(input logic [als_pkg::TICK_W-1:0] one_hi,
                              input logic [als_pkg::TICK_W-1:0] one_lo,
                              input logic [als_pkg::TICK_W-1:0] zero_hi,
                              input logic [als_pkg::TICK_W-1:0] zero_lo,
                              input logic [als_pkg::TICK_W-1:0] latch);
      write_reg(als_pkg::REG_ONE_HIGH, one_hi);
      write_reg(als_pkg::REG_ONE_LOW, one_lo);
      write_reg(als_pkg::REG_ZERO_HIGH, zero_hi);
      write_reg(als_pkg::REG_ZERO_LOW, zero_lo);
      write_reg(als_pkg::REG_LATCH_LOW, latch);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every predicted word has come back, then
   // let the output register settle before touching the registers.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Random words: mostly ticks to walk the frame, some color writes that
   // land on LEDs before, during and after their word is latched.
   task automatic send_random(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 15)
            send_word(als_pkg::REQ_WRITE,
                      (als_pkg::LED_INDEX_W)'($urandom_range(0, LEDS - 1)), $urandom,
                      1'($urandom_range(0, 1)));
         else
            send_word(als_pkg::REQ_TICK,
                      (als_pkg::LED_INDEX_W)'($urandom_range(0, LEDS - 1)), $urandom,
                      1'($urandom_range(0, 1)));
         idle_gap();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme color words into every LED, both button levels, a
      // write right after ticks to see the held level repeated.
      send_word(als_pkg::REQ_WRITE, 3'd0, 32'hFFFF_FFFF, 1'b0);
      send_word(als_pkg::REQ_WRITE, 3'd1, 32'hAAAA_AAAA, 1'b1);
      send_word(als_pkg::REQ_WRITE, 3'd2, 32'h5555_5555, 1'b0);
      send_word(als_pkg::REQ_WRITE, 3'd3, 32'h0000_0001, 1'b1);
      send_word(als_pkg::REQ_WRITE, 3'd4, 32'h8000_0000, 1'b0);
      send_word(als_pkg::REQ_WRITE, 3'd5, 32'h0F0F_0F0F, 1'b1);
      send_word(als_pkg::REQ_WRITE, 3'd6, 32'h0000_0000, 1'b0);
      send_word(als_pkg::REQ_WRITE, 3'd7, 32'h8000_0001, 1'b1);
      send_word(als_pkg::REQ_TICK, 3'd7, 32'hFFFF_FFFF, 1'b0);
      send_word(als_pkg::REQ_TICK, 3'd0, 32'h0000_0000, 1'b1);
      send_word(als_pkg::REQ_TICK, 3'd3, 32'h1234_5678, 1'b0);
      send_word(als_pkg::REQ_WRITE, 3'd2, 32'hC3C3_C3C3, 1'b1);
      send_word(als_pkg::REQ_TICK, 3'd5, 32'hFFFF_0000, 1'b1);
      drain();

      // Shortest bits; a zero count must act as one. Spare indexes are
      // dropped, and the opening period ends mid-count under the new latch.
      write_reg(REG_SPARE_5, 16'h0001);
      write_reg(REG_SPARE_6, 16'hFFFF);
      write_reg(REG_SPARE_7, 16'h0000);
      load_timing(16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
      send_random(400);
      drain();
      send_random(400);
      drain();

      // Short random timings, first stretch with no gaps or stalls.
      load_timing(rand_ticks(1, 2), rand_ticks(1, 2), rand_ticks(1, 2),
                  rand_ticks(1, 2), rand_ticks(1, 8));
      steady <= 1'b1;
      send_random(300);
      steady <= 1'b0;
      send_random(300);
      drain();

      // Wider timings, longer latch period.
      load_timing(rand_ticks(1, 4), rand_ticks(1, 4), rand_ticks(1, 4),
                  rand_ticks(1, 4), rand_ticks(20, 300));
      send_random(200);
      drain();

      // Top of the register range.
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_random(100);
      drain();

      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
